FILE: src/dq_pkg.sv
package dq_pkg;

  localparam int FUNC_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_PEEK_FRONT = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_PEEK_BACK  = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd6;

  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic clear;
  } dq_ctl_t;

endpackage

FILE: src/dq_cell.sv
module dq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dq_pkg::dq_ctl_t       ctl,
  input  logic [DATA_WIDTH-1:0] push_word,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic                  left_valid,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic                  right_valid,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  valid,
  output logic [DATA_WIDTH-1:0] back_word
);

  logic is_back;

  assign is_back   = valid && !right_valid;
  assign back_word = is_back ? data : '0;

  always_ff @(posedge clk) begin
    if (ctl.push_front) begin
      data <= left_data;
    end else if (ctl.pop_front) begin
      data <= right_data;
    end else if (ctl.push_back && left_valid && !valid) begin
      data <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.push_front) begin
      valid <= left_valid;
    end else if (ctl.pop_front) begin
      valid <= right_valid;
    end else if (ctl.push_back && left_valid) begin
      valid <= 1'b1;
    end else if (ctl.pop_back && is_back) begin
      valid <= 1'b0;
    end
  end

endmodule

FILE: src/double_ended_queue.sv
// Bounded double-ended queue of signed words.
// Input channel s_*: one operation per transfer; s_tuser carries func,
// s_tdata carries data_in. Push front/back, pop front/back, peek front/back
// and clear are supported; func code 7 does nothing and reports ok 0.
// Output channel m_*: exactly one result per operation, in order, with ok,
// the peeked word (zero unless a successful peek) and the empty flag, full
// flag and element count after the operation.
// Storage is a row of DEPTH cells; the front element sits in the first cell
// and pushes and pops at the front shift the whole row by one cell.
// The result is registered and appears in the cycle after the transfer.
// Throughput: one operation per cycle while m_tready is high; every
// operation takes effect in the cycle of its transfer.
// Reset empties the queue and drops any pending result.
// When the receiver stalls, the pending result holds in the output
// register and s_tready falls until that result is taken.
module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // data_in
  input  logic [((DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  // func
  input  logic [dq_pkg::FUNC_W-1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // ok, data_out, is_empty, is_full, occupancy
  output logic [((DATA_WIDTH+3+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata
);

  import dq_pkg::*;

  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int RES_W     = DATA_WIDTH + 3 + CNT_W;
  localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

  logic [DATA_WIDTH-1:0] data_in;
  logic [FUNC_W-1:0]     func;
  logic                  accept;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             empty;
  logic             full;

  dq_ctl_t               ctl;
  logic                  ok_next;
  logic [DATA_WIDTH-1:0] peek_next;

  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic [DATA_WIDTH-1:0] cell_back  [DEPTH];
  logic [DEPTH-1:0]      cell_valid;
  logic [DATA_WIDTH-1:0] back_word;

  logic [RES_W-1:0] result;

  assign data_in  = s_tdata[DATA_WIDTH-1:0];
  assign func     = s_tuser;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));

  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | cell_back[i];
    end
  end

  always_comb begin
    ctl        = '0;
    ok_next    = 1'b0;
    peek_next  = '0;
    count_next = count;
    case (func)
      FUNC_PUSH_FRONT: begin
        if (!full) begin
          ctl.push_front = accept;
          ok_next        = 1'b1;
          count_next     = count + 1'b1;
        end
      end
      FUNC_PUSH_BACK: begin
        if (!full) begin
          ctl.push_back = accept;
          ok_next       = 1'b1;
          count_next    = count + 1'b1;
        end
      end
      FUNC_POP_FRONT: begin
        if (!empty) begin
          ctl.pop_front = accept;
          ok_next       = 1'b1;
          count_next    = count - 1'b1;
        end
      end
      FUNC_POP_BACK: begin
        if (!empty) begin
          ctl.pop_back = accept;
          ok_next      = 1'b1;
          count_next   = count - 1'b1;
        end
      end
      FUNC_PEEK_FRONT: begin
        if (!empty) begin
          ok_next   = 1'b1;
          peek_next = cell_data[0];
        end
      end
      FUNC_PEEK_BACK: begin
        if (!empty) begin
          ok_next   = 1'b1;
          peek_next = back_word;
        end
      end
      FUNC_CLEAR: begin
        ctl.clear  = accept;
        ok_next    = !empty;
        count_next = '0;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic                  left_valid;
    logic [DATA_WIDTH-1:0] right_data;
    logic                  right_valid;

    if (i == 0) begin : g_first
      assign left_data  = data_in;
      assign left_valid = 1'b1;
    end else begin : g_inner_left
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    dq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .push_word  (data_in),
      .left_data  (left_data),
      .left_valid (left_valid),
      .right_data (right_data),
      .right_valid(right_valid),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .back_word  (cell_back[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= {count_next,
                 (count_next == CNT_W'(DEPTH)),
                 (count_next == '0),
                 peek_next,
                 ok_next};
    end
  end

  assign m_tdata = M_TDATA_W'(result);

  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    CNT_W'($countones(cell_valid)) == count)
    else $error("element count differs from occupied cells");

  a_cells_packed: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, cell_valid} + 1'b1))
    else $error("occupied cells are not packed at the front");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("element count exceeds depth");

  a_refused_push: assert property (@(posedge clk) disable iff (rst)
    accept && full && (func == FUNC_PUSH_FRONT || func == FUNC_PUSH_BACK)
    |=> $stable(cell_valid) && !result[0])
    else $error("push on a full queue changed state or reported success");

endmodule

FILE: dv/tb_double_ended_queue.sv
import dq_pkg::*;

class dq_scoreboard;
  localparam int DEPTH = 16;

  logic [31:0] cells [DEPTH];
  int unsigned head;
  int unsigned tail;
  int unsigned level;
  logic [39:0] status_q [$];
  int errors;

  function new();
    head = 0;
    tail = 0;
    level = 0;
    errors = 0;
  endfunction

  function int pending();
    return status_q.size();
  endfunction

  // advance the deque state by one operation and queue the status it reports
  function void note_op(logic [FUNC_W-1:0] f, logic [31:0] d);
    logic ok;
    logic [31:0] peek;
    bit empty;
    bit full;
    ok = 1'b0;
    peek = '0;
    empty = (level == 0);
    full = (level >= DEPTH);
    case (f)
      FUNC_PUSH_FRONT: begin
        if (!full) begin
          head = (head == 0) ? DEPTH - 1 : head - 1;
          cells[head] = d;
          level++;
          ok = 1'b1;
        end
      end
      FUNC_PUSH_BACK: begin
        if (!full) begin
          cells[tail] = d;
          tail = (tail + 1 >= DEPTH) ? 0 : tail + 1;
          level++;
          ok = 1'b1;
        end
      end
      FUNC_POP_FRONT: begin
        if (!empty) begin
          head = (head + 1 >= DEPTH) ? 0 : head + 1;
          level--;
          ok = 1'b1;
        end
      end
      FUNC_POP_BACK: begin
        if (!empty) begin
          tail = (tail == 0) ? DEPTH - 1 : tail - 1;
          level--;
          ok = 1'b1;
        end
      end
      FUNC_PEEK_FRONT: begin
        if (!empty) begin
          peek = cells[head];
          ok = 1'b1;
        end
      end
      FUNC_PEEK_BACK: begin
        if (!empty) begin
          peek = cells[(tail == 0) ? DEPTH - 1 : tail - 1];
          ok = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        ok = !empty;
        head = 0;
        tail = 0;
        level = 0;
      end
      default: begin
      end
    endcase
    status_q.push_back({level[4:0], (level >= DEPTH) ? 1'b1 : 1'b0,
                        (level == 0) ? 1'b1 : 1'b0, peek, ok});
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function void check_result(logic [39:0] got);
    logic [39:0] want;
    if (status_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      return;
    end
    want = status_q.pop_front();
    compare_field("ok", 32'(want[0]), 32'(got[0]));
    compare_field("data_out", want[32:1], got[32:1]);
    compare_field("is_empty", 32'(want[33]), 32'(got[33]));
    compare_field("is_full", 32'(want[34]), 32'(got[34]));
    compare_field("occupancy", 32'(want[39:35]), 32'(got[39:35]));
  endfunction
endclass

module tb_double_ended_queue;
  localparam int DEPTH = 16;
  localparam int DATA_WIDTH = 32;
  localparam int RES_W = 40;
  localparam int N_RANDOM = 1500;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_OFF = 120;
  localparam logic [FUNC_W-1:0] FUNC_NOOP = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DATA_WIDTH-1:0] s_tdata = '0;
  logic [FUNC_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [RES_W-1:0] m_tdata;

  dq_scoreboard sb = new();
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int idle_count = 0;

  double_ended_queue #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  function automatic int wait_cycles(bit steady);
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // bias 0 grows the deque toward full, 1 drains it, 2 stays balanced
  function automatic logic [FUNC_W-1:0] pick_func(int bias);
    int r;
    int push_pct;
    bit back;
    r = $urandom_range(0, 99);
    back = ($urandom_range(0, 1) == 1);
    push_pct = (bias == 0) ? 70 : (bias == 1) ? 25 : 45;
    if (r < 2) return FUNC_NOOP;
    if (r < 4) return FUNC_CLEAR;
    if (r < 4 + push_pct) return back ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
    if ($urandom_range(0, 2) != 0) return back ? FUNC_POP_BACK : FUNC_POP_FRONT;
    return back ? FUNC_PEEK_BACK : FUNC_PEEK_FRONT;
  endfunction

  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [31:0] d);
    int gap;
    gap = wait_cycles(tx_steady);
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_op(f, d);
  endtask

  task automatic drain_wait();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_directed();
    send_op(FUNC_POP_FRONT, pick_word());
    send_op(FUNC_POP_BACK, pick_word());
    send_op(FUNC_PEEK_FRONT, pick_word());
    send_op(FUNC_PEEK_BACK, pick_word());
    send_op(FUNC_CLEAR, pick_word());
    send_op(FUNC_NOOP, pick_word());
    send_op(FUNC_PUSH_FRONT, 32'h7fff_ffff);
    send_op(FUNC_PUSH_BACK, 32'h8000_0000);
    send_op(FUNC_PEEK_FRONT, $urandom());
    send_op(FUNC_PEEK_BACK, $urandom());
    for (int i = 0; i < DEPTH - 2; i++) begin
      send_op(i[0] ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT,
              (i == 0) ? 32'h0 : (i == 1) ? 32'hffff_ffff : $urandom());
    end
    send_op(FUNC_PUSH_FRONT, $urandom());
    send_op(FUNC_PUSH_BACK, $urandom());
    send_op(FUNC_PEEK_FRONT, $urandom());
    send_op(FUNC_CLEAR, $urandom());
  endtask

  initial begin
    int bias;
    bias = 2;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        bias = $urandom_range(0, 2);
      end
      if (n == N_RANDOM / 2) drain_wait();
      send_op(pick_func(bias), pick_word());
    end
    drain_wait();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_double_ended_queue: PASS");
    end else begin
      $display("tb_double_ended_queue: FAIL");
    end
    $finish;
  end

  initial begin
    int stall;
    int seen;
    seen = 0;
    wait (!rst);
    forever begin
      if (seen == 400) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
      if (seen % 64 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      stall = wait_cycles(rx_steady);
      repeat (stall) begin
        m_tready <= 1'b0;
        @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata);
      seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
    end
    if (idle_count >= STALL_LIMIT) begin
      $display("tb_double_ended_queue: FAIL");
      $finish;
    end
  end
endmodule
